/* rtl/wltpf_pkg.sv */
// ----------------------------------------------------------------------------
// wltpf_pkg
// Shared widths, register indexes, controller states and the command and
// status bundles of the windowed local top-count peak filter.
// ----------------------------------------------------------------------------
package wltpf_pkg;

	localparam int BIN_W        = 16;
	localparam int KEY_W        = 32;
	localparam int CFG_W        = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int RING_DEPTH   = 64;
	localparam int PTR_W        = $clog2(RING_DEPTH);
	localparam int CNT_W        = $clog2(RING_DEPTH + 1);
	localparam int MAX_WINDOW   = 32;
	localparam int RESULT_LIMIT = 32;
	localparam int NRES_W       = $clog2(RESULT_LIMIT + 1);
	localparam int ENTRY_W      = BIN_W + 2 * KEY_W;

	localparam logic [CFG_IDX_W-1:0] REG_INT_WIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INT_BEST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ISO_WIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ISO_BEST = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ERR,
		ST_DROP,
		ST_WRITE,
		ST_PEND_RD,
		ST_PEND_CMP,
		ST_CTX_RD,
		ST_CTX_CMP,
		ST_FLUSH,
		ST_CLEAR,
		ST_FIN_RD,
		ST_FIN_LAT,
		ST_FIN_SCAN,
		ST_FIN_DRAIN,
		ST_FIN_OUT
	} state_t;

	typedef enum logic [1:0] {
		RET_FULL,
		RET_PEND,
		RET_FLUSH
	} ret_t;

	typedef struct packed {
		logic ready;
		logic emit_err;
		logic drop_ctx;
		logic write;
		logic rd_opp;
		logic rd_ctx;
		logic set_ref_opp;
		logic set_ref_next;
		logic fin_start;
		logic scan_step;
		logic emit_fin;
		logic flush_mode;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic err;
		logic eol;
		logic full;
		logic all_pend;
		logic pend_zero;
		logic n_lim;
		logic pend_hit;
		logic ctx_hit;
		logic ctx_left;
		logic scan_done;
		logic out_free;
		logic pend_le_used;
	} sts_t;

	// zero when the test is disabled, else the window clipped to MAX_WINDOW
	function automatic logic [CFG_W-1:0] eff_win(input logic [CFG_W-1:0] win,
		input logic [CFG_W-1:0] best);
		logic [CFG_W-1:0] r;
		if (win == '0 || best == '0) begin
			r = '0;
		end else if (int'(win) > MAX_WINDOW) begin
			r = CFG_W'(MAX_WINDOW);
		end else begin
			r = win;
		end
		return r;
	endfunction

endpackage

/* rtl/wltpf_if.sv */
// ----------------------------------------------------------------------------
// wltpf_if
// Valid/ready channels for peak words and result words.
// ----------------------------------------------------------------------------
interface wltpf_peak_if;
	logic        valid;
	logic        ready;
	logic [15:0] peak_bin;
	logic [31:0] intensity_key;
	logic [31:0] isotope_key;
	logic        end_of_list;

	modport source (output valid, peak_bin, intensity_key, isotope_key, end_of_list,
		input ready);
	modport sink (input valid, peak_bin, intensity_key, isotope_key, end_of_list,
		output ready);
endinterface

interface wltpf_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_bin;
	logic        keep_by_intensity;
	logic        keep_by_isotope;
	logic        order_error;
	logic        last_result;

	modport source (output valid, result_bin, keep_by_intensity, keep_by_isotope,
		order_error, last_result, input ready);
	modport sink (input valid, result_bin, keep_by_intensity, keep_by_isotope,
		order_error, last_result, output ready);
endinterface

/* rtl/wltpf_ram.sv */
// ----------------------------------------------------------------------------
// wltpf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wltpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/wltpf_ctrl.sv */
// ----------------------------------------------------------------------------
// wltpf_ctrl
// Sequencer: order check, insert, finalize, context trim and flush.
// ----------------------------------------------------------------------------
module wltpf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  wltpf_pkg::sts_t sts,
	output wltpf_pkg::cmd_t cmd
);
	import wltpf_pkg::*;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_PEND;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.err) begin
					state_d = ST_ERR;
				end else if (sts.full && sts.all_pend) begin
					ret_d   = RET_FULL;
					state_d = ST_FIN_RD;
				end else if (sts.full) begin
					state_d = ST_DROP;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_ERR: begin
				if (sts.out_free) state_d = sts.eol ? ST_FLUSH : ST_IDLE;
			end
			ST_DROP:  state_d = ST_WRITE;
			ST_WRITE: state_d = sts.eol ? ST_FLUSH : ST_PEND_RD;
			ST_PEND_RD: begin
				state_d = sts.pend_zero ? ST_CTX_RD : ST_PEND_CMP;
			end
			ST_PEND_CMP: begin
				if (!sts.n_lim && sts.pend_hit) begin
					ret_d   = RET_PEND;
					state_d = ST_FIN_RD;
				end else begin
					state_d = ST_CTX_RD;
				end
			end
			ST_CTX_RD:  state_d = sts.ctx_left ? ST_CTX_CMP : ST_IDLE;
			ST_CTX_CMP: state_d = sts.ctx_hit ? ST_CTX_RD : ST_IDLE;
			ST_FLUSH: begin
				if (!sts.pend_zero && !sts.n_lim) begin
					ret_d   = RET_FLUSH;
					state_d = ST_FIN_RD;
				end else begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR:    state_d = ST_IDLE;
			ST_FIN_RD:   state_d = ST_FIN_LAT;
			ST_FIN_LAT:  state_d = ST_FIN_SCAN;
			ST_FIN_SCAN: begin
				if (sts.scan_done) state_d = ST_FIN_DRAIN;
			end
			ST_FIN_DRAIN: state_d = ST_FIN_OUT;
			ST_FIN_OUT: begin
				if (sts.out_free) begin
					case (ret_q)
						RET_FULL:  state_d = ST_DROP;
						RET_PEND:  state_d = ST_PEND_RD;
						RET_FLUSH: state_d = ST_FLUSH;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.flush_mode = (ret_q == RET_FLUSH);
		case (state_q)
			ST_IDLE:     cmd.ready    = 1'b1;
			ST_ERR:      cmd.emit_err = sts.out_free;
			ST_DROP:     cmd.drop_ctx = 1'b1;
			ST_WRITE:    cmd.write    = 1'b1;
			ST_PEND_RD: begin
				cmd.rd_opp       = !sts.pend_zero;
				cmd.set_ref_next = sts.pend_zero;
			end
			ST_PEND_CMP:  cmd.set_ref_opp = 1'b1;
			ST_CTX_RD:    cmd.rd_ctx      = sts.ctx_left;
			ST_CTX_CMP:   cmd.drop_ctx    = sts.ctx_hit;
			ST_CLEAR:     cmd.clear       = 1'b1;
			ST_FIN_RD:    cmd.rd_opp      = 1'b1;
			ST_FIN_LAT:   cmd.fin_start   = 1'b1;
			ST_FIN_SCAN:  cmd.scan_step   = !sts.scan_done;
			ST_FIN_OUT:   cmd.emit_fin    = sts.out_free;
			default: ;
		endcase
	end

endmodule

/* rtl/wltpf_dp.sv */
// ----------------------------------------------------------------------------
// wltpf_dp
// Datapath: peak ring, pointers and counts, neighbor scan, result register.
// ----------------------------------------------------------------------------
module wltpf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	wltpf_peak_if.sink                          peaks,
	wltpf_res_if.source                         results,
	input  logic                                cfg_we,
	input  logic [wltpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wltpf_pkg::CFG_W-1:0]         cfg_data,
	input  wltpf_pkg::cmd_t                     cmd,
	output wltpf_pkg::sts_t                     sts
);
	import wltpf_pkg::*;

	logic [CFG_W-1:0] int_win_q, int_best_q, iso_win_q, iso_best_q;
	logic [CFG_W-1:0] wi, ws, w;

	logic [BIN_W-1:0] bin_q, prev_q;
	logic [KEY_W-1:0] ik_q, sk_q;
	logic             eol_q, err_q, have_q;

	logic [PTR_W-1:0] ctx_q, opp_q, wptr_q, scan_ptr_q;
	logic [CNT_W-1:0] used_q, pend_q, remain_q;
	logic [NRES_W-1:0] n_q;
	logic [BIN_W:0]   ref_q;

	logic [BIN_W-1:0] cand_bin_q;
	logic [KEY_W-1:0] cand_ik_q, cand_sk_q;
	logic [CNT_W-1:0] cnt_i_q, cnt_s_q;
	logic             cmp_s1;

	logic [PTR_W-1:0]   raddr;
	logic [ENTRY_W-1:0] rdata;
	logic [BIN_W-1:0]   rd_bin, d;
	logic [KEY_W-1:0]   rd_ik, rd_sk;
	logic               accept, out_load, last;

	logic             out_valid_q;
	logic [BIN_W-1:0] out_bin_q;
	logic             out_ki_q, out_ks_q, out_err_q, out_last_q;

	assign wi = eff_win(int_win_q, int_best_q);
	assign ws = eff_win(iso_win_q, iso_best_q);
	assign w  = (wi > ws) ? wi : ws;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_win_q  <= '0;
			int_best_q <= '0;
			iso_win_q  <= '0;
			iso_best_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INT_WIN:  int_win_q  <= cfg_data;
				REG_INT_BEST: int_best_q <= cfg_data;
				REG_ISO_WIN:  iso_win_q  <= cfg_data;
				REG_ISO_BEST: iso_best_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept      = peaks.valid && cmd.ready;
	assign peaks.ready = cmd.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= peaks.peak_bin;
			ik_q  <= peaks.intensity_key;
			sk_q  <= peaks.isotope_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eol_q  <= 1'b0;
			err_q  <= 1'b0;
			have_q <= 1'b0;
			prev_q <= '0;
			ctx_q  <= '0;
			opp_q  <= '0;
			wptr_q <= '0;
			used_q <= '0;
			pend_q <= '0;
			n_q    <= '0;
		end else begin
			if (accept) begin
				eol_q <= peaks.end_of_list;
				err_q <= have_q && (peaks.peak_bin <= prev_q);
				n_q   <= '0;
			end
			if (cmd.emit_err) n_q <= n_q + 1'b1;
			if (cmd.drop_ctx) begin
				ctx_q  <= ctx_q + 1'b1;
				used_q <= used_q - 1'b1;
			end
			if (cmd.write) begin
				wptr_q <= wptr_q + 1'b1;
				used_q <= used_q + 1'b1;
				pend_q <= pend_q + 1'b1;
				prev_q <= bin_q;
				have_q <= 1'b1;
			end
			if (cmd.emit_fin) begin
				opp_q  <= opp_q + 1'b1;
				pend_q <= pend_q - 1'b1;
				n_q    <= n_q + 1'b1;
			end
			if (cmd.clear) begin
				ctx_q  <= '0;
				opp_q  <= '0;
				wptr_q <= '0;
				used_q <= '0;
				pend_q <= '0;
				prev_q <= '0;
				have_q <= 1'b0;
			end
		end
	end

	always_comb begin
		raddr = scan_ptr_q;
		if (cmd.rd_opp) begin
			raddr = opp_q;
		end else if (cmd.rd_ctx) begin
			raddr = ctx_q;
		end
	end

	wltpf_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (wptr_q),
		.wdata ({bin_q, ik_q, sk_q}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_bin = rdata[ENTRY_W-1 -: BIN_W];
	assign rd_ik  = rdata[2*KEY_W-1 -: KEY_W];
	assign rd_sk  = rdata[KEY_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.set_ref_opp) begin
			ref_q <= {1'b0, rd_bin};
		end else if (cmd.set_ref_next) begin
			ref_q <= {1'b0, bin_q} + 1'b1;
		end
	end

	// neighbor scan: one ring read issued per cycle, each compared on its registered read data
	assign d = (rd_bin > cand_bin_q) ? rd_bin - cand_bin_q : cand_bin_q - rd_bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1   <= 1'b0;
			remain_q <= '0;
		end else begin
			cmp_s1 <= cmd.scan_step;
			if (cmd.fin_start) begin
				remain_q <= used_q;
			end else if (cmd.scan_step) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_start) begin
			cand_bin_q <= rd_bin;
			cand_ik_q  <= rd_ik;
			cand_sk_q  <= rd_sk;
			scan_ptr_q <= ctx_q;
			cnt_i_q    <= '0;
			cnt_s_q    <= '0;
		end else begin
			if (cmd.scan_step) scan_ptr_q <= scan_ptr_q + 1'b1;
			if (cmp_s1) begin
				if (d < {{(BIN_W-CFG_W){1'b0}}, wi} && rd_ik > cand_ik_q) begin
					cnt_i_q <= cnt_i_q + 1'b1;
				end
				if (d < {{(BIN_W-CFG_W){1'b0}}, ws} && rd_sk > cand_sk_q) begin
					cnt_s_q <= cnt_s_q + 1'b1;
				end
			end
		end
	end

	// result register
	assign out_load = cmd.emit_err || cmd.emit_fin;
	assign last     = cmd.emit_err
		? (eol_q && pend_q == '0)
		: (cmd.flush_mode && (pend_q == CNT_W'(1) || n_q == NRES_W'(RESULT_LIMIT - 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bin_q  <= cmd.emit_err ? bin_q : cand_bin_q;
			out_ki_q   <= cmd.emit_fin && (wi == '0 || cnt_i_q < {1'b0, int_best_q});
			out_ks_q   <= cmd.emit_fin && (ws == '0 || cnt_s_q < {1'b0, iso_best_q});
			out_err_q  <= cmd.emit_err;
			out_last_q <= last;
		end
	end

	assign results.valid             = out_valid_q;
	assign results.result_bin        = out_bin_q;
	assign results.keep_by_intensity = out_ki_q;
	assign results.keep_by_isotope   = out_ks_q;
	assign results.order_error       = out_err_q;
	assign results.last_result       = out_last_q;

	assign sts.in_valid     = peaks.valid;
	assign sts.err          = err_q;
	assign sts.eol          = eol_q;
	assign sts.full         = (used_q == CNT_W'(RING_DEPTH));
	assign sts.all_pend     = (used_q == pend_q);
	assign sts.pend_zero    = (pend_q == '0);
	assign sts.n_lim        = (n_q == NRES_W'(RESULT_LIMIT));
	assign sts.pend_hit     = ({2'b0, rd_bin} + {{(BIN_W-CFG_W+2){1'b0}}, w})
		<= {2'b0, bin_q};
	assign sts.ctx_hit      = ({2'b0, rd_bin} + {{(BIN_W-CFG_W+2){1'b0}}, w})
		<= {1'b0, ref_q};
	assign sts.ctx_left     = (used_q > pend_q);
	assign sts.scan_done    = (remain_q == '0);
	assign sts.out_free     = !out_valid_q || results.ready;
	assign sts.pend_le_used = (pend_q <= used_q);

endmodule

/* rtl/windowed_local_top_x_peak_filter.sv */
// ----------------------------------------------------------------------------
// windowed_local_top_x_peak_filter
// Keeps peaks that rank in the local top count by intensity and by isotope
// score within a window of bins.
// ----------------------------------------------------------------------------
// Peak words enter on "peaks" in strictly increasing bin order; result words
// leave on "results", one per finalized peak or per rejected (out of order)
// peak. The four 6-bit registers are written through cfg_we/cfg_index/
// cfg_data, by the user only while the block is idle; the block itself
// does not enforce it. One peak is taken at a time. A peak that finalizes
// nothing is inserted, then takes one ring read per pending/context check.
// For every finalized peak the candidate is read from the 64-entry ring
// RAM, then every used ring entry is read through the single read port,
// one per cycle, and compared on both keys.
// An end_of_list peak flushes up to 32 pending peaks and marks the final
// word with last_result.
// Reset empties the ring and clears the registers; no clearing pass.
// A stalled receiver holds the result register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module windowed_local_top_x_peak_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	wltpf_peak_if.sink                      peaks,
	wltpf_res_if.source                     results,
	input  logic                            cfg_we,
	input  logic [wltpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wltpf_pkg::CFG_W-1:0]     cfg_data
);
	import wltpf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wltpf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	wltpf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.peaks     (peaks),
		.results   (results),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_err || cmd.emit_fin) |-> sts.out_free)
		else $error("result word overwritten");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(peaks.valid && peaks.ready) |=> !peaks.ready)
		else $error("second peak taken while busy");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		sts.pend_le_used)
		else $error("pending count above ring use");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed local top-count peak filter: drives
// peak words with random idling, predicts result words with a local copy of
// the ring, and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb;
	import wltpf_pkg::*;

	typedef struct packed {
		logic [15:0] bin;
		logic        keep_int;
		logic        keep_iso;
		logic        oerr;
		logic        last;
	} res_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	wltpf_peak_if peaks ();
	wltpf_res_if results ();

	windowed_local_top_x_peak_filter dut (
		.clk(clk), .arst_n(arst_n), .peaks(peaks.sink), .results(results.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// predictor state
	logic [15:0] r_bin [RING_DEPTH];
	logic [31:0] r_int [RING_DEPTH];
	logic [31:0] r_iso [RING_DEPTH];
	int ctx_p, pend_p, wr_p, used_n, pend_n;
	logic [15:0] last_bin;
	bit seen;
	logic [5:0] int_win, int_best, iso_win, iso_best;

	res_word_t expected_words[$];
	int errors = 0;
	int mismatches = 0;
	bit quiet = 1'b0;
	int hold_cycles = 0;

	function automatic void queue_word(res_word_t r);
		expected_words.insert(expected_words.size(), r);
	endfunction

	function automatic int nxt(int p);
		return (p == RING_DEPTH - 1) ? 0 : p + 1;
	endfunction

	function automatic int win_of(logic [5:0] w, logic [5:0] b);
		if (w == 0 || b == 0) return 0;
		return (w > MAX_WINDOW) ? MAX_WINDOW : int'(w);
	endfunction

	function automatic bit ranks_high(int idx, bit iso, int w, int best);
		int cnt = 0;
		int p = ctx_p;
		int d;
		logic [31:0] ka, kb;
		if (w == 0) return 1'b1;
		for (int k = 0; k < used_n; k++) begin
			d = (r_bin[p] > r_bin[idx]) ? r_bin[p] - r_bin[idx] : r_bin[idx] - r_bin[p];
			ka = iso ? r_iso[p] : r_int[p];
			kb = iso ? r_iso[idx] : r_int[idx];
			if (d < w && ka > kb) cnt++;
			p = nxt(p);
		end
		return cnt < best;
	endfunction

	function automatic void finalize_peak(int wi, int ws);
		res_word_t r;
		r.bin = r_bin[pend_p];
		r.keep_int = ranks_high(pend_p, 1'b0, wi, int'(int_best));
		r.keep_iso = ranks_high(pend_p, 1'b1, ws, int'(iso_best));
		r.oerr = 1'b0;
		r.last = 1'b0;
		queue_word(r);
		pend_p = nxt(pend_p);
		pend_n--;
	endfunction

	function automatic void clear_ring();
		ctx_p = 0; pend_p = 0; wr_p = 0; used_n = 0; pend_n = 0;
		last_bin = '0; seen = 1'b0;
	endfunction

	function automatic void predict_peak(logic [15:0] bin, logic [31:0] ik,
		logic [31:0] sk, bit eol);
		int wi, ws, w, n, refb;
		res_word_t r;
		wi = win_of(int_win, int_best);
		ws = win_of(iso_win, iso_best);
		w = (wi > ws) ? wi : ws;
		n = 0;
		if (seen && bin <= last_bin) begin
			r = '{bin: bin, keep_int: 1'b0, keep_iso: 1'b0, oerr: 1'b1, last: 1'b0};
			queue_word(r);
			n = 1;
		end else begin
			if (used_n >= RING_DEPTH) begin
				if (used_n == pend_n) begin
					finalize_peak(wi, ws);
					n++;
				end
				ctx_p = nxt(ctx_p); used_n--;
			end
			r_bin[wr_p] = bin; r_int[wr_p] = ik; r_iso[wr_p] = sk;
			wr_p = nxt(wr_p); used_n++; pend_n++;
			last_bin = bin; seen = 1'b1;
			if (!eol) begin
				while (pend_n > 0 && n < RESULT_LIMIT && int'(r_bin[pend_p]) + w <= int'(bin)) begin
					finalize_peak(wi, ws);
					n++;
				end
				refb = (pend_n > 0) ? int'(r_bin[pend_p]) : int'(bin) + 1;
				while (used_n > pend_n && int'(r_bin[ctx_p]) + w <= refb) begin
					ctx_p = nxt(ctx_p); used_n--;
				end
			end
		end
		if (eol) begin
			while (pend_n > 0 && n < RESULT_LIMIT) begin
				finalize_peak(wi, ws);
				n++;
			end
			if (n > 0) expected_words[$].last = 1'b1;
			clear_ring();
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		res_word_t got, exp_w;
		if (arst_n && results.valid && results.ready) begin
			got = '{bin: results.result_bin, keep_int: results.keep_by_intensity,
				keep_iso: results.keep_by_isotope, oerr: results.order_error,
				last: results.last_result};
			if (expected_words.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result word %h", got);
			end else begin
				exp_w = expected_words.pop_front();
				if (got !== exp_w) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp bin=%0d ki=%b ks=%b oe=%b last=%b, got bin=%0d ki=%b ks=%b oe=%b last=%b",
							exp_w.bin, exp_w.keep_int, exp_w.keep_iso, exp_w.oerr, exp_w.last,
							got.bin, got.keep_int, got.keep_iso, got.oerr, got.last);
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int burst;
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				results.ready <= 1'b0;
				hold_cycles--;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 6);
				results.ready <= 1'b0;
				repeat (burst) @(negedge clk);
				results.ready <= 1'b1;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	task automatic send_peak(logic [15:0] bin, logic [31:0] ik, logic [31:0] sk, bit eol);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			peaks.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		peaks.valid = 1'b1;
		peaks.peak_bin = bin;
		peaks.intensity_key = ik;
		peaks.isotope_key = sk;
		peaks.end_of_list = eol;
		@(posedge clk);
		while (!peaks.ready) @(posedge clk);
		predict_peak(bin, ik, sk, eol);
		@(negedge clk);
		peaks.valid = 1'b0;
	endtask

	task automatic drain();
		while (expected_words.size() != 0) @(negedge clk);
		// a peak that yields nothing may still be in the sequencer
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [5:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_INT_WIN:  int_win = v;
			REG_INT_BEST: int_best = v;
			REG_ISO_WIN:  iso_win = v;
			default:      iso_best = v;
		endcase
	endtask

	task automatic set_config(logic [5:0] a, logic [5:0] b, logic [5:0] c, logic [5:0] d);
		drain();
		write_reg(REG_INT_WIN, a);
		write_reg(REG_INT_BEST, b);
		write_reg(REG_ISO_WIN, c);
		write_reg(REG_ISO_BEST, d);
	endtask

	// random spectrum of len peaks, with occasional misordered bins
	task automatic send_spectrum(int len, int max_step, int bad_pct);
		logic [15:0] bin;
		int step;
		bin = 16'($urandom_range(0, 200));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < bad_pct && i > 0)
				send_peak(16'(bin - $urandom_range(0, 3)), $urandom, $urandom, i == len - 1);
			else begin
				send_peak(bin, ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 7)),
					($urandom_range(0, 1) ? $urandom : $urandom_range(0, 7)), i == len - 1);
				step = $urandom_range(1, max_step);
				bin = (int'(bin) + step > 65535) ? bin : 16'(int'(bin) + step);
			end
		end
	endtask

	task automatic test_directed();
		set_config(6'd3, 6'd1, 6'd2, 6'd2);
		send_peak(16'd0, 32'd0, 32'd0, 1'b0);
		send_peak(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_peak(16'd1, 32'd5, 32'd5, 1'b0);          // repeated bin
		send_peak(16'd2, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_peak(16'd9, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_peak(16'd4, 32'd1, 32'd1, 1'b1);          // error on the last input
		send_peak(16'd7, 32'd1, 32'd1, 1'b1);          // lone flush
		send_peak(16'd100, 32'd1, 32'd1, 1'b0);
		send_peak(16'd50, 32'd1, 32'd1, 1'b1);         // error, flush of one
		send_peak(16'd65534, 32'd3, 32'd3, 1'b0);
		send_peak(16'd65535, 32'd2, 32'd9, 1'b1);
		send_peak(16'd5, 32'd2, 32'd9, 1'b0);
		send_peak(16'd5, 32'd2, 32'd9, 1'b1);          // error, flush of one
	endtask

	task automatic test_windows();
		set_config(6'd0, 6'd0, 6'd0, 6'd0);
		send_spectrum(8, 3, 10);
		set_config(6'd63, 6'd1, 6'd40, 6'd63);         // wide windows clip
		send_spectrum(20, 4, 10);
		set_config(6'd32, 6'd63, 6'd1, 6'd1);
		send_spectrum(15, 2, 10);
		set_config(6'd5, 6'd0, 6'd0, 6'd3);
		send_spectrum(15, 3, 10);
	endtask

	task automatic test_full_ring();
		// wide window with dense bins: pending and context peaks crowd the ring
		set_config(6'd32, 6'd2, 6'd32, 6'd5);
		send_spectrum(80, 1, 0);
		// long flush beyond the result limit
		send_spectrum(45, 1, 0);
	endtask

	task automatic test_backpressure();
		set_config(6'd2, 6'd1, 6'd3, 6'd2);
		hold_cycles = 400;
		send_spectrum(20, 3, 0);
		drain();
		send_spectrum(10, 3, 10);
	endtask

	task automatic test_random();
		int left = 150;
		int len;
		while (left > 0) begin
			set_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			len = $urandom_range(3, 25);
			if (left < 50) quiet = 1'b1;
			send_spectrum(len, $urandom_range(1, 8), 8);
			left -= len;
		end
	endtask

	initial begin
		peaks.valid = 1'b0;
		peaks.peak_bin = '0;
		peaks.intensity_key = '0;
		peaks.isotope_key = '0;
		peaks.end_of_list = 1'b0;
		int_win = '0; int_best = '0; iso_win = '0; iso_best = '0;
		clear_ring();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_windows();
		test_full_ring();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0 && expected_words.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule
